### rtl/core/ordered_list_insert_delete_defines.svh
// assertion macros shared by the checker of the ordered list block
// no dependencies; included by files that carry concurrent assertions
`ifndef ORDERED_LIST_INSERT_DELETE_DEFINES_SVH
`define ORDERED_LIST_INSERT_DELETE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define OLID_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("olid assertion failed");

// next-cycle implication, disabled during reset
`define OLID_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("olid assertion failed");

`endif

### rtl/core/olid_pkg.sv
// shared types and codes for the ordered list block
// no dependencies; used by the controller, the top level and the checker
`timescale 1ns / 1ps
package olid_pkg;

  localparam int unsigned DataW = 32;

  typedef enum logic [1:0] {
    REQ_INSERT    = 2'd0,
    REQ_DEL_HEAD  = 2'd1,
    REQ_DEL_TAIL  = 2'd2,
    REQ_DEL_VALUE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic                    valid;
    status_t                 status;
    logic signed [DataW-1:0] value;
  } result_t;

endpackage

### rtl/core/ordered_list_insert_delete.sv
// Ordered list of up to CAPACITY signed 32-bit values kept in arrival order.
// Input channel: in_valid / in_stall with req_type and item_value; an item is
// taken at a clock edge where in_valid is high and in_stall is low.
// Output channel: out_valid / out_stall with status, result_value and
// entry_count; exactly one result item per request item, in order.
// Insert and any request on an empty list go from dispatch straight to the
// result state; delete-tail first reads the last entry; delete-head and
// delete-value search with one read per entry and, on a hit, move each
// remaining entry down one slot, paced by the single read port of the store.
// in_stall is high from accept until the result is handed to the output
// register, so one request is in work at a time; the next request is taken
// while the previous result still waits in the output register.
// A stalled result holds out_valid and its fields steady; if a second result
// is ready meanwhile the sequencer waits for the output register to drain.
// Reset (rst, synchronous, active high) empties the list and drops any pending
// result; the entry store itself is not cleared and needs no clearing pass.
// entry_count reports the count modulo 32.
// Depends on olid_pkg, olid_ctrl and olid_mem.
`timescale 1ns / 1ps
module ordered_list_insert_delete #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        req_type,
  input  logic signed [olid_pkg::DataW-1:0] item_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        status,
  output logic signed [olid_pkg::DataW-1:0] result_value,
  output logic [4:0]                        entry_count
);
  import olid_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned LW = $clog2(CAPACITY + 1);

  logic              busy;
  logic              slot_free;
  result_t           res;
  logic [LW-1:0]     count;
  logic [LW+4:0]     count_ext;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DataW-1:0]  wr_data;
  logic [AW-1:0]     rd_addr;
  logic [DataW-1:0]  rd_data;

  olid_ctrl #(
    .CAPACITY(CAPACITY),
    .AW      (AW),
    .LW      (LW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .req_type  (req_type),
    .item_value(item_value),
    .busy      (busy),
    .slot_free (slot_free),
    .res       (res),
    .count     (count),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  olid_mem #(
    .DEPTH(CAPACITY),
    .AW   (AW),
    .DW   (DataW)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign in_stall  = busy;
  assign slot_free = !out_valid || !out_stall;
  assign count_ext = {5'b0, count};

  // output register parts the sequencer from the receiver
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid && slot_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && slot_free) begin
      status       <= res.status;
      result_value <= res.value;
      entry_count  <= count_ext[4:0];
    end
  end

endmodule

### rtl/core/olid_mem.sv
// single-port-write, single-port-read store for the list entries
// registered read data; depends on nothing
`timescale 1ns / 1ps
module olid_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned DW    = 32
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/core/olid_ctrl.sv
// sequencer for the ordered list: walks the entry store one address a cycle
// with one shared equality compare; uses olid_pkg and drives olid_mem
`timescale 1ns / 1ps
module olid_ctrl #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned AW       = 4,
  parameter int unsigned LW       = 5
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic [1:0]                        req_type,
  input  logic signed [olid_pkg::DataW-1:0] item_value,
  output logic                              busy,
  input  logic                              slot_free,
  output olid_pkg::result_t                 res,
  output logic [LW-1:0]                     count,
  output logic                              wr_en,
  output logic [AW-1:0]                     wr_addr,
  output logic [olid_pkg::DataW-1:0]        wr_data,
  output logic [AW-1:0]                     rd_addr,
  input  logic [olid_pkg::DataW-1:0]        rd_data
);
  import olid_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SEARCH,
    S_SHIFT,
    S_TAIL,
    S_OUT
  } state_t;

  state_t              state;
  req_t                kind;
  logic [DataW-1:0]    val;
  logic [LW-1:0]       len;
  logic [LW-1:0]       ptr;
  logic [AW-1:0]       didx;
  logic                pend;
  status_t             res_status;
  logic signed [DataW-1:0] res_value;

  logic issue;
  logic hit;
  logic full;

  assign full  = (len == LW'(CAPACITY));
  assign issue = (ptr < len);
  // shared compare: delete-head matches the first entry unconditionally
  assign hit   = pend && ((kind == REQ_DEL_HEAD) || (rd_data == val));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = rd_data;
    rd_addr = ptr[AW-1:0];
    unique case (state)
      S_DISPATCH: begin
        if (kind == REQ_INSERT && !full) begin
          wr_en   = 1'b1;
          wr_addr = len[AW-1:0];
          wr_data = val;
        end
        rd_addr = AW'(len - LW'(1));
      end
      S_SHIFT: begin
        // data in flight belongs one slot above where it lands
        if (pend) begin
          wr_en   = 1'b1;
          wr_addr = didx - AW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      len   <= '0;
      pend  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            kind  <= req_t'(req_type);
            val   <= item_value;
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          priority if (kind == REQ_INSERT) begin
            if (full) begin
              res_status <= ST_FULL;
              res_value  <= '0;
            end else begin
              len        <= len + LW'(1);
              res_status <= ST_OK;
              res_value  <= val;
            end
            state <= S_OUT;
          end else if (len == '0) begin
            res_status <= ST_EMPTY;
            res_value  <= '0;
            state      <= S_OUT;
          end else if (kind == REQ_DEL_TAIL) begin
            state <= S_TAIL;
          end else begin
            ptr   <= '0;
            pend  <= 1'b0;
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          pend <= issue;
          didx <= ptr[AW-1:0];
          if (issue) begin
            ptr <= ptr + LW'(1);
          end
          // on a hit the read just issued is the first one the shift needs
          priority if (hit) begin
            res_value <= rd_data;
            state     <= S_SHIFT;
          end else if (!pend && !issue) begin
            res_status <= ST_NOT_FOUND;
            res_value  <= '0;
            state      <= S_OUT;
          end else begin
          end
        end
        S_SHIFT: begin
          pend <= issue;
          didx <= ptr[AW-1:0];
          if (issue) begin
            ptr <= ptr + LW'(1);
          end
          if (!pend && !issue) begin
            len        <= len - LW'(1);
            res_status <= ST_OK;
            state      <= S_OUT;
          end
        end
        S_TAIL: begin
          len        <= len - LW'(1);
          res_status <= ST_OK;
          res_value  <= rd_data;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy       = (state != S_IDLE);
  assign res.valid  = (state == S_OUT);
  assign res.status = res_status;
  assign res.value  = res_value;
  assign count      = len;

endmodule

### rtl/core/olid_chk.sv
// port-level checker for the ordered list block, bound to the top level
// depends on olid_pkg and ordered_list_insert_delete_defines.svh
`timescale 1ns / 1ps
`include "ordered_list_insert_delete_defines.svh"
module olid_chk #(
  parameter int unsigned CAPACITY = 16
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [1:0]                        status,
  input logic signed [olid_pkg::DataW-1:0] result_value,
  input logic [4:0]                        entry_count
);
  import olid_pkg::*;

  // failed requests never carry a value
  `OLID_ASSERT_IMP(a_fail_zero, out_valid && (status != ST_OK), result_value == '0)
  // a full list reports the capacity as its count
  `OLID_ASSERT_IMP(a_full_count, out_valid && (status == ST_FULL), entry_count == 5'(CAPACITY))
  // an empty list reports zero entries
  `OLID_ASSERT_IMP(a_empty_count, out_valid && (status == ST_EMPTY), entry_count == 5'd0)
  // one request at a time: busy right after an accept
  `OLID_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // stalled result holds
  `OLID_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(result_value))

endmodule

bind ordered_list_insert_delete olid_chk #(.CAPACITY(CAPACITY)) u_olid_chk (.*);
